[design/bufc_pkg.sv]
// shared types and constants for the buffered serial port ring control block
package bufc_pkg;

   // ring sizes and derived widths
   localparam int RX_DEPTH   = 64;
   localparam int TX_DEPTH   = 64;
   localparam int RX_PTR_W   = $clog2(RX_DEPTH);
   localparam int TX_PTR_W   = $clog2(TX_DEPTH);
   localparam int RX_FILL_W  = $clog2(RX_DEPTH + 1);
   localparam int TX_FILL_W  = $clog2(TX_DEPTH + 1);
   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 7;

   // command codes
   typedef enum logic [2:0] {
      CMD_HOST_PUT   = 3'd0,
      CMD_HOST_GET   = 3'd1,
      CMD_LINE_BYTE  = 3'd2,
      CMD_LINE_READY = 3'd3,
      CMD_LINE_ERR   = 3'd4,
      CMD_CLEAR_RX   = 3'd5,
      CMD_CLEAR_TX   = 3'd6
   } cmd_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_TX_FULL  = 2'd1,
      STAT_RX_EMPTY = 2'd2,
      STAT_RX_ERROR = 2'd3
   } status_type;

   // receive event codes
   typedef enum logic [1:0] {
      RXEV_NONE    = 2'd0,
      RXEV_STORED  = 2'd1,
      RXEV_FULL    = 2'd2,
      RXEV_DROPPED = 2'd3
   } rx_event_type;

   typedef struct packed {
      cmd_type            command;
      logic [BYTE_W-1:0]  data_byte;
      logic [3:0]         line_errors;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [BYTE_W-1:0]   data_out;
      logic                data_out_valid;
      logic [COUNT_W-1:0]  rx_count;
      logic [COUNT_W-1:0]  tx_count;
      logic                tx_irq_on;
      logic                tx_char_done;
      logic                tx_ring_drained;
      rx_event_type        rx_event;
      logic                error_pending;
   } rsp_type;

endpackage

[design/bufc_ram.sv]
// generic single write port, single read port ram with registered read
module bufc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[design/buffered_uart_fifo_control_top.sv]
// top level of the buffered serial port ring control block
//
// Usage: each transfer on the req_ channel carries one command (host put,
// host get, line byte in, line ready, line errors, clear rx, clear tx).
// Every command yields exactly one transfer on the rsp_ channel, in order.
// The command is decoded and the ring pointers, fills and flags are updated
// at the edge where it is accepted; at that same edge the result, less any
// popped byte, is caught in a stage register and the ring memory read is
// issued. When the stage register moves on, the popped byte joins the result
// as it loads the output register, and rsp_valid rises with that load, so the
// result transfer passes through both the stage and the output register. One
// command can be accepted every cycle while req_ready is high; each uses the
// single read port of its ring memory at most once.
// Reset clears all pointers, fills and flags and empties the pipeline; the
// ring contents are not cleared and are only read after being written.
// When the receiver holds rsp_ready low, the output register holds its
// result, the stage register fills, and req_ready then falls until the
// output register is taken.
module buffered_uart_fifo_control_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bufc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bufc_pkg::rsp_type rsp_data
);

   // ring control state
   logic [bufc_pkg::RX_PTR_W-1:0]  rx_rd_ptr_ff, rx_rd_ptr_in;
   logic [bufc_pkg::RX_PTR_W-1:0]  rx_wr_ptr_ff, rx_wr_ptr_in;
   logic [bufc_pkg::RX_FILL_W-1:0] rx_fill_ff, rx_fill_in;
   logic [bufc_pkg::TX_PTR_W-1:0]  tx_rd_ptr_ff, tx_rd_ptr_in;
   logic [bufc_pkg::TX_PTR_W-1:0]  tx_wr_ptr_ff, tx_wr_ptr_in;
   logic [bufc_pkg::TX_FILL_W-1:0] tx_fill_ff, tx_fill_in;
   logic overflow_ff, overflow_in;
   logic line_err_ff, line_err_in;
   logic tx_busy_ff, tx_busy_in;
   logic tx_irq_en_ff, tx_irq_en_in;

   // stage and output registers
   logic              stage_valid_ff, stage_valid_in;
   bufc_pkg::rsp_type stage_rsp_ff, stage_rsp_in;
   logic              stage_rd_rx_ff, stage_rd_tx_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   bufc_pkg::rsp_type rsp_ff, rsp_in;

   // memory access strobes
   logic rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
   logic [bufc_pkg::BYTE_W-1:0] rx_rd_data, tx_rd_data;
   logic pop_rx, pop_tx, push_rx, push_tx;

   logic req_xfer, out_free, stage_move;

   // handshake
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign stage_move = stage_valid_ff && out_free;
   assign req_ready  = !stage_valid_ff || out_free;
   assign req_xfer   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // command decode and next control state
   always_comb begin
      rx_rd_ptr_in = rx_rd_ptr_ff;
      rx_wr_ptr_in = rx_wr_ptr_ff;
      rx_fill_in   = rx_fill_ff;
      tx_rd_ptr_in = tx_rd_ptr_ff;
      tx_wr_ptr_in = tx_wr_ptr_ff;
      tx_fill_in   = tx_fill_ff;
      overflow_in  = overflow_ff;
      line_err_in  = line_err_ff;
      tx_busy_in   = tx_busy_ff;
      tx_irq_en_in = tx_irq_en_ff;
      push_rx = 1'b0;
      push_tx = 1'b0;
      pop_rx  = 1'b0;
      pop_tx  = 1'b0;
      stage_rsp_in = '0;
      unique case (req_data.command)
         bufc_pkg::CMD_HOST_PUT: begin
            if (tx_fill_ff == bufc_pkg::TX_FILL_W'(bufc_pkg::TX_DEPTH)) begin
               stage_rsp_in.status = bufc_pkg::STAT_TX_FULL;
            end else begin
               push_tx      = 1'b1;
               tx_wr_ptr_in = (tx_wr_ptr_ff == bufc_pkg::TX_PTR_W'(bufc_pkg::TX_DEPTH - 1))
                              ? '0 : tx_wr_ptr_ff + 1'b1;
               tx_fill_in   = tx_fill_ff + 1'b1;
               tx_irq_en_in = 1'b1;
            end
         end
         bufc_pkg::CMD_HOST_GET: begin
            if (rx_fill_ff == '0) begin
               stage_rsp_in.status = bufc_pkg::STAT_RX_EMPTY;
            end else begin
               pop_rx       = 1'b1;
               rx_rd_ptr_in = (rx_rd_ptr_ff == bufc_pkg::RX_PTR_W'(bufc_pkg::RX_DEPTH - 1))
                              ? '0 : rx_rd_ptr_ff + 1'b1;
               rx_fill_in   = rx_fill_ff - 1'b1;
               stage_rsp_in.data_out_valid = 1'b1;
               stage_rsp_in.status = (overflow_ff || line_err_ff)
                                     ? bufc_pkg::STAT_RX_ERROR : bufc_pkg::STAT_OK;
               overflow_in  = 1'b0;
               line_err_in  = 1'b0;
            end
         end
         bufc_pkg::CMD_LINE_BYTE: begin
            if (rx_fill_ff != bufc_pkg::RX_FILL_W'(bufc_pkg::RX_DEPTH)) begin
               push_rx      = 1'b1;
               rx_wr_ptr_in = (rx_wr_ptr_ff == bufc_pkg::RX_PTR_W'(bufc_pkg::RX_DEPTH - 1))
                              ? '0 : rx_wr_ptr_ff + 1'b1;
               rx_fill_in   = rx_fill_ff + 1'b1;
               stage_rsp_in.rx_event =
                  (rx_fill_ff == bufc_pkg::RX_FILL_W'(bufc_pkg::RX_DEPTH - 1))
                  ? bufc_pkg::RXEV_FULL : bufc_pkg::RXEV_STORED;
            end else begin
               overflow_in = 1'b1;
               stage_rsp_in.rx_event = bufc_pkg::RXEV_DROPPED;
            end
         end
         bufc_pkg::CMD_LINE_READY: begin
            stage_rsp_in.tx_char_done = tx_busy_ff;
            if (tx_fill_ff != '0) begin
               pop_tx       = 1'b1;
               tx_rd_ptr_in = (tx_rd_ptr_ff == bufc_pkg::TX_PTR_W'(bufc_pkg::TX_DEPTH - 1))
                              ? '0 : tx_rd_ptr_ff + 1'b1;
               tx_fill_in   = tx_fill_ff - 1'b1;
               tx_busy_in   = 1'b1;
               stage_rsp_in.data_out_valid = 1'b1;
            end else begin
               tx_busy_in   = 1'b0;
               tx_irq_en_in = 1'b0;
               stage_rsp_in.tx_ring_drained = 1'b1;
            end
         end
         bufc_pkg::CMD_LINE_ERR: begin
            if (req_data.line_errors != '0) begin
               line_err_in = 1'b1;
            end
         end
         bufc_pkg::CMD_CLEAR_RX: begin
            rx_fill_in   = '0;
            rx_rd_ptr_in = '0;
            rx_wr_ptr_in = '0;
         end
         bufc_pkg::CMD_CLEAR_TX: begin
            tx_fill_in   = '0;
            tx_rd_ptr_in = '0;
            tx_wr_ptr_in = '0;
         end
         default: begin
         end
      endcase
      stage_rsp_in.rx_count      = bufc_pkg::COUNT_W'(rx_fill_in);
      stage_rsp_in.tx_count      = bufc_pkg::COUNT_W'(tx_fill_in);
      stage_rsp_in.tx_irq_on     = tx_irq_en_in;
      stage_rsp_in.error_pending = line_err_in;
   end

   assign rx_wr_en = req_xfer && push_rx;
   assign tx_wr_en = req_xfer && push_tx;
   assign rx_rd_en = req_xfer && pop_rx;
   assign tx_rd_en = req_xfer && pop_tx;

   // stage and output valid next values
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_xfer) begin
         stage_valid_in = 1'b1;
      end else if (stage_move) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (stage_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // popped byte joins the staged result
   always_comb begin
      rsp_in = stage_rsp_ff;
      if (stage_rd_rx_ff) begin
         rsp_in.data_out = rx_rd_data;
      end else if (stage_rd_tx_ff) begin
         rsp_in.data_out = tx_rd_data;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_rd_ptr_ff   <= '0;
         rx_wr_ptr_ff   <= '0;
         rx_fill_ff     <= '0;
         tx_rd_ptr_ff   <= '0;
         tx_wr_ptr_ff   <= '0;
         tx_fill_ff     <= '0;
         overflow_ff    <= 1'b0;
         line_err_ff    <= 1'b0;
         tx_busy_ff     <= 1'b0;
         tx_irq_en_ff   <= 1'b0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_xfer) begin
            rx_rd_ptr_ff <= rx_rd_ptr_in;
            rx_wr_ptr_ff <= rx_wr_ptr_in;
            rx_fill_ff   <= rx_fill_in;
            tx_rd_ptr_ff <= tx_rd_ptr_in;
            tx_wr_ptr_ff <= tx_wr_ptr_in;
            tx_fill_ff   <= tx_fill_in;
            overflow_ff  <= overflow_in;
            line_err_ff  <= line_err_in;
            tx_busy_ff   <= tx_busy_in;
            tx_irq_en_ff <= tx_irq_en_in;
         end
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         stage_rsp_ff   <= stage_rsp_in;
         stage_rd_rx_ff <= pop_rx;
         stage_rd_tx_ff <= pop_tx;
      end
      if (stage_move) begin
         rsp_ff <= rsp_in;
      end
   end

   // receive ring storage
   bufc_ram #(
      .WIDTH(bufc_pkg::BYTE_W),
      .DEPTH(bufc_pkg::RX_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wr_ptr_ff),
      .wr_data (req_data.data_byte),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_rd_ptr_ff),
      .rd_data (rx_rd_data)
   );

   // transmit ring storage
   bufc_ram #(
      .WIDTH(bufc_pkg::BYTE_W),
      .DEPTH(bufc_pkg::TX_DEPTH)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_wr_ptr_ff),
      .wr_data (req_data.data_byte),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_rd_ptr_ff),
      .rd_data (tx_rd_data)
   );

   // fills never pass the ring depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rx_fill_ff <= bufc_pkg::RX_FILL_W'(bufc_pkg::RX_DEPTH) &&
      tx_fill_ff <= bufc_pkg::TX_FILL_W'(bufc_pkg::TX_DEPTH))
      else $error("ring fill beyond depth");

   // a popped byte never comes with a full or empty status
   a_pop_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.data_out_valid |->
         rsp_ff.status != bufc_pkg::STAT_TX_FULL &&
         rsp_ff.status != bufc_pkg::STAT_RX_EMPTY)
      else $error("popped byte with failing status");

   // a staged result is kept while the output register is blocked
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !out_free |=> stage_valid_ff && $stable(stage_rsp_ff))
      else $error("staged result lost under stall");

   // an accepted put to a ring with space raises the transmit fill by one
   a_put_fill: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_data.command == bufc_pkg::CMD_HOST_PUT &&
      tx_fill_ff != bufc_pkg::TX_FILL_W'(bufc_pkg::TX_DEPTH) |=>
         tx_fill_ff == $past(tx_fill_ff) + 1'b1)
      else $error("transmit fill not advanced on put");

endmodule
